[rtl/core/tdq_pkg.sv]
`timescale 1ns / 1ps

package tdq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 32;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  localparam int unsigned TIME_W    = 48;
  localparam int unsigned REL_W     = TIME_W + 1;
  localparam int unsigned DELAY_W   = 24;
  localparam int unsigned OUT_PAY_W = 32;
  localparam int unsigned EXT_PAY_W = 64;

  localparam logic OP_DELAY  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // commands broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic pop;
  } tdq_cmd_t;

  // status of the chain seen by the controller
  typedef struct packed {
    logic head_due;
    logic next_due;
    logic full;
  } tdq_stat_t;

endpackage

[rtl/core/tdq_cell.sv]
`timescale 1ns / 1ps

module tdq_cell import tdq_pkg::*; #(
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tdq_cmd_t                cmd_i,
  // entry offered for insertion
  input  logic [REL_W-1:0]        new_rel_i,
  input  logic [TIME_W-1:0]       new_stamp_i,
  input  logic [PAYLOAD_BITS-1:0] new_pay_i,
  // left neighbor (closer to the head)
  input  logic                    prev_keep_i,
  input  logic                    prev_valid_i,
  input  logic [REL_W-1:0]        prev_rel_i,
  input  logic [TIME_W-1:0]       prev_stamp_i,
  input  logic [PAYLOAD_BITS-1:0] prev_pay_i,
  // right neighbor (closer to the tail)
  input  logic                    next_valid_i,
  input  logic [REL_W-1:0]        next_rel_i,
  input  logic [TIME_W-1:0]       next_stamp_i,
  input  logic [PAYLOAD_BITS-1:0] next_pay_i,
  // own contents
  output logic                    keep_o,
  output logic                    valid_o,
  output logic [REL_W-1:0]        rel_o,
  output logic [TIME_W-1:0]       stamp_o,
  output logic [PAYLOAD_BITS-1:0] pay_o
);

  logic                    valid_q, valid_d;
  logic [REL_W-1:0]        rel_q, rel_d;
  logic [TIME_W-1:0]       stamp_q, stamp_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    keep;

  // entry stays in place when it releases no later than the new one
  assign keep = valid_q && (rel_q <= new_rel_i);

  always_comb begin
    valid_d = valid_q;
    rel_d   = rel_q;
    stamp_d = stamp_q;
    pay_d   = pay_q;
    if (cmd_i.insert && !keep) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        rel_d   = new_rel_i;
        stamp_d = new_stamp_i;
        pay_d   = new_pay_i;
      end else begin
        valid_d = prev_valid_i;
        rel_d   = prev_rel_i;
        stamp_d = prev_stamp_i;
        pay_d   = prev_pay_i;
      end
    end else if (cmd_i.pop) begin
      valid_d = next_valid_i;
      rel_d   = next_rel_i;
      stamp_d = next_stamp_i;
      pay_d   = next_pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rel_q   <= rel_d;
    stamp_q <= stamp_d;
    pay_q   <= pay_d;
  end

  assign keep_o  = keep;
  assign valid_o = valid_q;
  assign rel_o   = rel_q;
  assign stamp_o = stamp_q;
  assign pay_o   = pay_q;

endmodule

[rtl/core/tdq_chain.sv]
`timescale 1ns / 1ps

module tdq_chain import tdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tdq_cmd_t                cmd_i,
  input  logic [TIME_W-1:0]       now_i,
  input  logic [REL_W-1:0]        new_rel_i,
  input  logic [TIME_W-1:0]       new_stamp_i,
  input  logic [PAYLOAD_BITS-1:0] new_pay_i,
  output tdq_stat_t               stat_o,
  output logic [TIME_W-1:0]       head_stamp_o,
  output logic [PAYLOAD_BITS-1:0] head_pay_o
);

  logic                    keep  [QUEUE_DEPTH];
  logic                    valid [QUEUE_DEPTH];
  logic [REL_W-1:0]        rel   [QUEUE_DEPTH];
  logic [TIME_W-1:0]       stamp [QUEUE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay   [QUEUE_DEPTH];

  logic [REL_W-1:0] now_ext;
  assign now_ext = {1'b0, now_i};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                    p_keep, p_valid, n_valid;
    logic [REL_W-1:0]        p_rel, n_rel;
    logic [TIME_W-1:0]       p_stamp, n_stamp;
    logic [PAYLOAD_BITS-1:0] p_pay, n_pay;

    if (i == 0) begin : g_first
      // head cell takes the new entry whenever it is displaced
      assign p_keep  = 1'b1;
      assign p_valid = 1'b0;
      assign p_rel   = '0;
      assign p_stamp = '0;
      assign p_pay   = '0;
    end else begin : g_mid
      assign p_keep  = keep[i-1];
      assign p_valid = valid[i-1];
      assign p_rel   = rel[i-1];
      assign p_stamp = stamp[i-1];
      assign p_pay   = pay[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_valid = 1'b0;
      assign n_rel   = '0;
      assign n_stamp = '0;
      assign n_pay   = '0;
    end else begin : g_inner
      assign n_valid = valid[i+1];
      assign n_rel   = rel[i+1];
      assign n_stamp = stamp[i+1];
      assign n_pay   = pay[i+1];
    end

    tdq_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd_i),
      .new_rel_i   (new_rel_i),
      .new_stamp_i (new_stamp_i),
      .new_pay_i   (new_pay_i),
      .prev_keep_i (p_keep),
      .prev_valid_i(p_valid),
      .prev_rel_i  (p_rel),
      .prev_stamp_i(p_stamp),
      .prev_pay_i  (p_pay),
      .next_valid_i(n_valid),
      .next_rel_i  (n_rel),
      .next_stamp_i(n_stamp),
      .next_pay_i  (n_pay),
      .keep_o      (keep[i]),
      .valid_o     (valid[i]),
      .rel_o       (rel[i]),
      .stamp_o     (stamp[i]),
      .pay_o       (pay[i])
    );
  end

  if (QUEUE_DEPTH > 1) begin : g_next_due
    assign stat_o.next_due = valid[1] && (rel[1] <= now_ext);
  end else begin : g_no_next
    assign stat_o.next_due = 1'b0;
  end

  assign stat_o.head_due = valid[0] && (rel[0] <= now_ext);
  // entries fill from the head, so the tail cell tells the queue is full
  assign stat_o.full     = valid[QUEUE_DEPTH-1];
  assign head_stamp_o    = stamp[0];
  assign head_pay_o      = pay[0];

endmodule

[rtl/core/timed_release_delay_queue_unit.sv]
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   op_i, time_now_i, delay_value_i, payload_i
// out       output     out_valid_o / out_stall_i out_payload_o, out_stamp_o, dropped_o, last_o
// cfg       input      cfg_wr_en_i               cfg_wr_data_i (simulate_delay)
//
// a delay update does not stall the input; a sample, once taken, stalls the input while
// the controller works: with the queue off it passes the sample straight through, with it
// on it inserts or drops the sample, releases each due entry, then sees the head is not due
// reset clears the cell valid bits, the delay, the mode bit and the controller at once
// a stalled output holds the controller in place and so lengthens the input stall

module timed_release_delay_queue_unit import tdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_wr_en_i,
  input  logic                 cfg_wr_data_i,
  // input transactions
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 op_i,
  input  logic [TIME_W-1:0]    time_now_i,
  input  logic [DELAY_W-1:0]   delay_value_i,
  input  logic [OUT_PAY_W-1:0] payload_i,
  // output transactions
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OUT_PAY_W-1:0] out_payload_o,
  output logic [TIME_W-1:0]    out_stamp_o,
  output logic                 dropped_o,
  output logic                 last_o
);

  // controller states
  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_SAMPLE  = 2'd1;
  localparam logic [1:0] S_RELEASE = 2'd2;

  logic [1:0] state_q, state_d;

  // mode bit and current delay
  logic               sim_q;
  logic [DELAY_W-1:0] delay_q;

  // sample under work
  logic [TIME_W-1:0]       now_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [EXT_PAY_W-1:0]    in_pay_ext;
  logic [REL_W-1:0]        new_rel;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [OUT_PAY_W-1:0] out_pay_q, out_pay_d;
  logic [TIME_W-1:0]    out_stamp_q, out_stamp_d;
  logic                 out_drop_q, out_drop_d;
  logic                 out_last_q, out_last_d;
  logic                 out_free;

  // chain interface
  tdq_cmd_t                cmd;
  tdq_stat_t               stat;
  logic [TIME_W-1:0]       head_stamp;
  logic [PAYLOAD_BITS-1:0] head_pay;
  logic [EXT_PAY_W-1:0]    pay_q_ext, head_pay_ext;

  logic in_accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // payload kept to the configured width, shown on the fixed-width output
  assign in_pay_ext   = EXT_PAY_W'(payload_i);
  assign pay_q_ext    = EXT_PAY_W'(pay_q);
  assign head_pay_ext = EXT_PAY_W'(head_pay);

  // release time: stamp plus delay, one bit wider than time
  assign new_rel = {1'b0, now_q} + REL_W'(delay_q);

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q && out_stall_i;
    out_pay_d   = out_pay_q;
    out_stamp_d = out_stamp_q;
    out_drop_d  = out_drop_q;
    out_last_d  = out_last_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (op_i == OP_SAMPLE)) begin
          state_d = S_SAMPLE;
        end
      end
      S_SAMPLE: begin
        if (!sim_q) begin
          // pass straight through
          if (out_free) begin
            out_valid_d = 1'b1;
            out_pay_d   = pay_q_ext[OUT_PAY_W-1:0];
            out_stamp_d = now_q;
            out_drop_d  = 1'b0;
            out_last_d  = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (stat.full) begin
          // queue full: report the sample as dropped, then release as usual
          if (out_free) begin
            out_valid_d = 1'b1;
            out_pay_d   = pay_q_ext[OUT_PAY_W-1:0];
            out_stamp_d = now_q;
            out_drop_d  = 1'b1;
            out_last_d  = !stat.head_due;
            state_d     = S_RELEASE;
          end
        end else begin
          cmd.insert = 1'b1;
          state_d    = S_RELEASE;
        end
      end
      S_RELEASE: begin
        if (stat.head_due) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_pay_d   = head_pay_ext[OUT_PAY_W-1:0];
            out_stamp_d = head_stamp;
            out_drop_d  = 1'b0;
            // the entry behind the head decides whether more follow
            out_last_d  = !stat.next_due;
            cmd.pop     = 1'b1;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sim_q       <= 1'b0;
      delay_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        sim_q <= cfg_wr_data_i;
      end
      if (in_accept && (op_i == OP_DELAY)) begin
        delay_q <= delay_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q <= time_now_i;
      pay_q <= in_pay_ext[PAYLOAD_BITS-1:0];
    end
    out_pay_q   <= out_pay_d;
    out_stamp_q <= out_stamp_d;
    out_drop_q  <= out_drop_d;
    out_last_q  <= out_last_d;
  end

  tdq_chain #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .now_i       (now_q),
    .new_rel_i   (new_rel),
    .new_stamp_i (now_q),
    .new_pay_i   (pay_q),
    .stat_o      (stat),
    .head_stamp_o(head_stamp),
    .head_pay_o  (head_pay)
  );

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_pay_q;
  assign out_stamp_o   = out_stamp_q;
  assign dropped_o     = out_drop_q;
  assign last_o        = out_last_q;

endmodule
